// ===== sv/bvop_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and helper functions shared by the vendor option parser
package bvop_pkg;

	typedef enum logic [1:0] {
		PH_TAG = 2'd0,
		PH_LEN = 2'd1,
		PH_VAL = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_MASK        = 3'd1,
		EV_GATEWAY     = 3'd2,
		EV_DNS         = 3'd3,
		EV_HOST_BYTE   = 3'd4,
		EV_DOMAIN_BYTE = 3'd5,
		EV_NAME_END    = 3'd6,
		EV_AREA_DONE   = 3'd7
	} ev_t;

	localparam logic [7:0] TAG_PAD     = 8'd0;
	localparam logic [7:0] TAG_MASK    = 8'd1;
	localparam logic [7:0] TAG_ROUTER  = 8'd3;
	localparam logic [7:0] TAG_DNS     = 8'd6;
	localparam logic [7:0] TAG_HOST    = 8'd12;
	localparam logic [7:0] TAG_DOMAIN  = 8'd15;
	localparam logic [7:0] TAG_END     = 8'd255;

	localparam logic [7:0] ADDR_LEN = 8'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       area_start;
		logic       area_last;
		logic       clear_found;
	} item_t;

	typedef struct packed {
		ev_t         event_res;
		logic [31:0] value;
		logic [4:0]  found_flags;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  current_tag;
		logic [7:0]  bytes_left;
		logic        option_accepted;
		logic [31:0] address_shift;
		logic [4:0]  found;
		logic        area_finished;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:           PH_TAG,
		current_tag:     8'd0,
		bytes_left:      8'd0,
		option_accepted: 1'b0,
		address_shift:   32'd0,
		found:           5'd0,
		area_finished:   1'b0
	};

	function automatic logic [4:0] tag_bit(input logic [7:0] tag);
		logic [4:0] r;
		case (tag)
			TAG_MASK:    r = 5'b00001;
			TAG_ROUTER:  r = 5'b00010;
			TAG_DNS:     r = 5'b00100;
			TAG_HOST:    r = 5'b01000;
			TAG_DOMAIN:  r = 5'b10000;
			default:     r = 5'b00000;
		endcase
		return r;
	endfunction

	function automatic logic tag_is_name(input logic [7:0] tag);
		return (tag == TAG_HOST) || (tag == TAG_DOMAIN);
	endfunction

	function automatic ev_t addr_event(input logic [7:0] tag);
		ev_t r;
		if (tag == TAG_MASK) begin
			r = EV_MASK;
		end else if (tag == TAG_ROUTER) begin
			r = EV_GATEWAY;
		end else begin
			r = EV_DNS;
		end
		return r;
	endfunction

endpackage

// ===== sv/bootp_vendor_option_parser.sv =====
`timescale 1ns / 1ps
// top level of the bootp vendor option parser
// Takes the vendor area that follows the magic cookie one byte per clock and walks its
// tag-length-value options, reporting subnet mask, gateway and domain server addresses,
// streaming host and domain name bytes, and flagging the end of each area. One result
// transfer comes out for every byte taken. A byte is registered on input, handled by a
// single pass of combinational logic against the parser state, and lands in the result
// register. A new byte can be taken every cycle while the result side does not stall;
// while it stalls, one more byte is held in the input register before item_stall rises.
module bootp_vendor_option_parser import bvop_pkg::*; #(
	parameter int NAME_CAP = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic    valid_s1;
	item_t   item_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	logic    out_free;
	logic    adv;
	logic    accept;

	assign adv        = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	bvop_step #(
		.NAME_CAP(NAME_CAP)
	) u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	bvop_out_stage u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (adv),
		.d     (res_nxt),
		.stall (result_stall),
		.free  (out_free),
		.valid (result_valid),
		.q     (result)
	);

endmodule

// ===== sv/bvop_step.sv =====
`timescale 1ns / 1ps
// next state and result for one vendor area byte
module bvop_step import bvop_pkg::*; #(
	parameter int NAME_CAP = 64
) (
	input  item_t   item,
	input  state_t  cur,
	output state_t  nxt,
	output result_t res
);

	always_comb begin
		state_t     s;
		ev_t        ev;
		logic [31:0] val;
		logic [4:0] tbit;
		logic       done;
		logic [7:0] b;

		s    = cur;
		ev   = EV_NONE;
		val  = 32'd0;
		b    = item.data_byte;
		tbit = tag_bit(cur.current_tag);
		done = (cur.bytes_left <= 8'd1);

		if (item.area_start) begin
			s.phase           = PH_TAG;
			s.area_finished   = 1'b0;
			s.option_accepted = 1'b0;
			s.bytes_left      = 8'd0;
		end
		if (item.clear_found) begin
			s.found = 5'd0;
		end

		if (!s.area_finished) begin
			case (s.phase)
				PH_LEN: begin
					s.bytes_left      = b;
					s.address_shift   = 32'd0;
					s.option_accepted = 1'b0;
					if ((tbit != 5'd0) && ((s.found & tbit) == 5'd0)) begin
						if (tag_is_name(s.current_tag)) begin
							s.option_accepted = ({1'b0, b} < 9'(NAME_CAP));
						end else begin
							s.option_accepted = (b == ADDR_LEN);
						end
					end
					if (b == 8'd0) begin
						s.phase = PH_TAG;
						if (s.option_accepted) begin
							s.found = s.found | tbit;
							ev      = EV_NAME_END;
							val     = {8'd0, s.current_tag, 16'd0};
						end
						s.option_accepted = 1'b0;
					end else begin
						s.phase = PH_VAL;
					end
				end
				PH_VAL: begin
					s.bytes_left = done ? 8'd0 : (s.bytes_left - 8'd1);
					if (s.option_accepted) begin
						if (tag_is_name(s.current_tag)) begin
							if (done) begin
								ev  = EV_NAME_END;
								val = {8'd0, s.current_tag, 7'd0, 1'b1, b};
							end else begin
								ev  = (s.current_tag == TAG_HOST) ? EV_HOST_BYTE
									: EV_DOMAIN_BYTE;
								val = {24'd0, b};
							end
						end else begin
							s.address_shift = {s.address_shift[23:0], b};
							if (done) begin
								ev  = addr_event(s.current_tag);
								val = s.address_shift;
							end
						end
						if (done) begin
							s.found = s.found | tbit;
						end
					end
					if (done) begin
						s.phase           = PH_TAG;
						s.option_accepted = 1'b0;
					end
				end
				default: begin
					s.phase = PH_TAG;
					if (b == TAG_END) begin
						ev              = EV_AREA_DONE;
						s.area_finished = 1'b1;
					end else if (b != TAG_PAD) begin
						s.current_tag = b;
						s.phase       = PH_LEN;
					end
				end
			endcase

			if (item.area_last) begin
				if (ev == EV_NONE) begin
					ev = EV_AREA_DONE;
				end
				s.phase           = PH_TAG;
				s.option_accepted = 1'b0;
				s.bytes_left      = 8'd0;
				s.area_finished   = 1'b1;
			end
		end

		nxt             = s;
		res.event_res   = ev;
		res.value       = val;
		res.found_flags = s.found;
	end

endmodule

// ===== sv/bvop_out_stage.sv =====
`timescale 1ns / 1ps
// result register with valid/stall handshake toward the consumer
module bvop_out_stage import bvop_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t d,
	input  logic    stall,
	output logic    free,
	output logic    valid,
	output result_t q
);

	logic    valid_q;
	result_t data_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

// ===== sv/bvop_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the vendor option parser and their binding
module bvop_checker import bvop_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// an address is only reported together with its found flag
	a_addr_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((result.event_res == EV_MASK && !result.found_flags[0])
			|| (result.event_res == EV_GATEWAY && !result.found_flags[1])
			|| (result.event_res == EV_DNS && !result.found_flags[2])) |-> 1'b0)
		else $error("address event without its found flag");

	// name end carries a name tag and sets that flag
	a_name_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.event_res == EV_NAME_END |->
			result.value[31:24] == 8'd0 && result.value[15:9] == 7'd0
			&& ((result.value[23:16] == TAG_HOST && result.found_flags[3])
			|| (result.value[23:16] == TAG_DOMAIN && result.found_flags[4])))
		else $error("malformed name end");

	// no value on empty or area done transfers
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_res == EV_NONE || result.event_res == EV_AREA_DONE)
			|-> result.value == 32'd0)
		else $error("value set on an event without payload");

	// name bytes use only the low byte
	a_name_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_res == EV_HOST_BYTE
			|| result.event_res == EV_DOMAIN_BYTE) |-> result.value[31:8] == 24'd0)
		else $error("name byte wider than a byte");

endmodule

bind bootp_vendor_option_parser bvop_checker u_bvop_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// testbench for the bootp vendor option parser: directed table, then random vendor areas
module tb;
	import bvop_pkg::*;

	localparam int NAME_CAP = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_BYTES = 375;
	localparam int DIR_ROWS = 25;

	localparam result_t IDLE_RESULT = '{EV_NONE, 32'd0, 5'd0};

	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{TAG_MASK, 1'b1, 1'b0, 1'b0}, 1'b1, IDLE_RESULT},
		'{'{8'h04, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'hFF, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h80, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h01, 1'b0, 1'b0, 1'b0}, 1'b1, '{EV_MASK, 32'hFF008001, 5'b00001}},
		'{'{TAG_PAD, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{TAG_DNS, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h02, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'hAA, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h55, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{TAG_HOST, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h02, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h61, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h62, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{TAG_DOMAIN, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, '{EV_NAME_END, 32'h000F0000, 5'b11001}},
		'{'{8'd200, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h01, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h07, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{TAG_END, 1'b0, 1'b0, 1'b0}, 1'b1, '{EV_AREA_DONE, 32'd0, 5'b11001}},
		'{'{TAG_END, 1'b0, 1'b1, 1'b0}, 1'b1, '{EV_NONE, 32'd0, 5'b11001}},
		'{'{TAG_ROUTER, 1'b1, 1'b0, 1'b1}, 1'b0, IDLE_RESULT},
		'{'{8'h04, 1'b0, 1'b0, 1'b0}, 1'b0, IDLE_RESULT},
		'{'{8'h0A, 1'b0, 1'b1, 1'b0}, 1'b1, '{EV_AREA_DONE, 32'd0, 5'd0}}
	};

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// parser state as predicted
	phase_t      walk_phase;
	logic [7:0]  opt_tag;
	logic [7:0]  opt_left;
	logic        opt_taken;
	logic [31:0] addr_acc;
	logic [4:0]  held_flags;
	logic        area_closed;

	result_t parse_results_due[$];

	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles = 0;
	int fault_count = 0;
	int bytes_sent;
	int areas_sent;
	int results_checked = 0;
	int addr_seen = 0;
	int names_seen = 0;

	bootp_vendor_option_parser #(.NAME_CAP(NAME_CAP)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [4:0] held_mask(input logic [7:0] t);
		logic [4:0] m;
		m = 5'd0;
		if (t == TAG_MASK) m[0] = 1'b1;
		if (t == TAG_ROUTER) m[1] = 1'b1;
		if (t == TAG_DNS) m[2] = 1'b1;
		if (t == TAG_HOST) m[3] = 1'b1;
		if (t == TAG_DOMAIN) m[4] = 1'b1;
		return m;
	endfunction

	function automatic result_t parse_byte(input item_t it);
		result_t    r;
		logic [4:0] fbit;
		logic       named_opt;
		logic       last_one;
		r = IDLE_RESULT;
		if (it.area_start) begin
			walk_phase = PH_TAG;
			area_closed = 1'b0;
			opt_taken = 1'b0;
			opt_left = 8'd0;
		end
		if (it.clear_found) begin
			held_flags = 5'd0;
		end
		if (!area_closed) begin
			fbit = held_mask(opt_tag);
			named_opt = (opt_tag == TAG_HOST) || (opt_tag == TAG_DOMAIN);
			case (walk_phase)
				PH_LEN: begin
					opt_left = it.data_byte;
					addr_acc = 32'd0;
					opt_taken = 1'b0;
					if (fbit != 5'd0 && (held_flags & fbit) == 5'd0) begin
						if (named_opt) begin
							opt_taken = (it.data_byte < NAME_CAP);
						end else begin
							opt_taken = (it.data_byte == ADDR_LEN);
						end
					end
					if (it.data_byte == 8'd0) begin
						walk_phase = PH_TAG;
						if (opt_taken) begin
							held_flags = held_flags | fbit;
							r.event_res = EV_NAME_END;
							r.value = {8'd0, opt_tag, 16'd0};
						end
						opt_taken = 1'b0;
					end else begin
						walk_phase = PH_VAL;
					end
				end
				PH_VAL: begin
					last_one = (opt_left <= 8'd1);
					opt_left = last_one ? 8'd0 : opt_left - 8'd1;
					if (opt_taken) begin
						if (named_opt) begin
							if (last_one) begin
								r.event_res = EV_NAME_END;
								r.value = {8'd0, opt_tag, 7'd0, 1'b1, it.data_byte};
							end else begin
								if (opt_tag == TAG_HOST) begin
									r.event_res = EV_HOST_BYTE;
								end else begin
									r.event_res = EV_DOMAIN_BYTE;
								end
								r.value = {24'd0, it.data_byte};
							end
						end else begin
							addr_acc = {addr_acc[23:0], it.data_byte};
							if (last_one) begin
								if (opt_tag == TAG_MASK) begin
									r.event_res = EV_MASK;
								end else if (opt_tag == TAG_ROUTER) begin
									r.event_res = EV_GATEWAY;
								end else begin
									r.event_res = EV_DNS;
								end
								r.value = addr_acc;
							end
						end
						if (last_one) begin
							held_flags = held_flags | fbit;
						end
					end
					if (last_one) begin
						walk_phase = PH_TAG;
						opt_taken = 1'b0;
					end
				end
				default: begin
					walk_phase = PH_TAG;
					if (it.data_byte == TAG_END) begin
						r.event_res = EV_AREA_DONE;
						area_closed = 1'b1;
					end else if (it.data_byte != TAG_PAD) begin
						opt_tag = it.data_byte;
						walk_phase = PH_LEN;
					end
				end
			endcase
			if (it.area_last) begin
				if (r.event_res == EV_NONE) begin
					r.event_res = EV_AREA_DONE;
				end
				walk_phase = PH_TAG;
				opt_taken = 1'b0;
				opt_left = 8'd0;
				area_closed = 1'b1;
			end
		end
		r.found_flags = held_flags;
		return r;
	endfunction

	function automatic item_t plain_byte(input logic [7:0] b);
		item_t r;
		r = '0;
		r.data_byte = b;
		return r;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	task automatic send_byte(input item_t stim, input logic typed, input result_t want);
		result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item = stim;
		item_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (item_stall);
		predicted = parse_byte(stim);
		parse_results_due.push_back(typed ? want : predicted);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_area();
		item_t      area_q[$];
		item_t      it;
		logic [7:0] t;
		int         len;
		int         cut;
		area_q = {};
		if ($urandom_range(0, 7) == 0) begin
			// noise: random bytes with random marks
			repeat ($urandom_range(1, 12)) begin
				it.data_byte = 8'($urandom_range(0, 255));
				it.area_start = ($urandom_range(0, 3) == 0);
				it.area_last = ($urandom_range(0, 3) == 0);
				it.clear_found = ($urandom_range(0, 3) == 0);
				area_q.push_back(it);
			end
		end else begin
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 9))
					0: t = TAG_MASK;
					1: t = TAG_ROUTER;
					2: t = TAG_DNS;
					3, 4: t = TAG_HOST;
					5, 6: t = TAG_DOMAIN;
					7: t = TAG_PAD;
					default: t = 8'($urandom_range(0, 254));
				endcase
				area_q.push_back(plain_byte(t));
				if (t != TAG_PAD) begin
					if (t == TAG_HOST || t == TAG_DOMAIN) begin
						case ($urandom_range(0, 15))
							0: len = NAME_CAP - 1 + $urandom_range(0, 2);
							1: len = $urandom_range(0, 255);
							default: len = $urandom_range(0, 6);
						endcase
					end else if (t == TAG_MASK || t == TAG_ROUTER || t == TAG_DNS) begin
						len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : ADDR_LEN;
					end else begin
						len = $urandom_range(0, 6);
					end
					area_q.push_back(plain_byte(8'(len)));
					repeat (len) area_q.push_back(plain_byte(8'($urandom_range(0, 255))));
				end
			end
			if ($urandom_range(0, 1) == 1) begin
				area_q.push_back(plain_byte(TAG_END));
				repeat ($urandom_range(0, 2)) area_q.push_back(plain_byte(8'($urandom_range(0, 255))));
			end
			// truncated area drops the open option
			if ($urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, area_q.size());
				while (area_q.size() > cut) void'(area_q.pop_back());
			end
			foreach (area_q[i]) area_q[i].clear_found = ($urandom_range(0, 63) == 0);
			area_q[0].area_start = 1'b1;
			area_q[0].clear_found = ($urandom_range(0, 1) == 1);
			area_q[area_q.size() - 1].area_last = ($urandom_range(0, 9) != 0);
		end
		foreach (area_q[i]) send_byte(area_q[i], 1'b0, IDLE_RESULT);
		areas_sent++;
	endtask

	always @(negedge clk) begin
		result_stall = ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		result_t due;
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (result_valid && !result_stall) begin
				if (parse_results_due.size() == 0) begin
					note_fault($sformatf("result with nothing expected: ev %0d value %h flags %b",
						result.event_res, result.value, result.found_flags));
				end else begin
					due = parse_results_due.pop_front();
					results_checked++;
					if (due.event_res inside {EV_MASK, EV_GATEWAY, EV_DNS}) addr_seen++;
					if (due.event_res == EV_NAME_END) names_seen++;
					if (result.event_res !== due.event_res || result.value !== due.value ||
						result.found_flags !== due.found_flags) begin
						note_fault($sformatf(
							"mismatch: expected ev %0d value %h flags %b, got ev %0d value %h flags %b",
							due.event_res, due.value, due.found_flags,
							result.event_res, result.value, result.found_flags));
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results outstanding",
					idle_cycles, parse_results_due.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int start_count;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		send_idle_pct = 14;
		recv_idle_pct = 66;
		bytes_sent = 0;
		areas_sent = 0;
		walk_phase = PH_TAG;
		opt_tag = 8'd0;
		opt_left = 8'd0;
		opt_taken = 1'b0;
		addr_acc = 32'd0;
		held_flags = 5'd0;
		area_closed = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_byte(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int pass = 0; pass < 3; pass++) begin
			case (pass)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 66;
				end
				1: begin
					send_idle_pct = 66;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			start_count = bytes_sent;
			while (bytes_sent - start_count < PHASE_BYTES) send_area();
		end
		item_valid = 1'b0;

		while (parse_results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d bytes in %0d vendor areas, %0d results checked",
			bytes_sent, areas_sent, results_checked);
		$display("%0d address captures and %0d completed names seen, %0d faults",
			addr_seen, names_seen, fault_count);
		if (fault_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
